/* design/pgs_pkg.sv */
package pgs_pkg;

    localparam int LOG_STEPS = 16;
    localparam int EXP_STEPS = 16;
    localparam int PIPE_LAT  = 43;

    typedef enum logic [1:0] {
        REG_SPECULAR_GAIN = 2'd0,
        REG_LOBE_EXPONENT = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic vld;
        logic zero;
    } t_ctl;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] b;
        res = '0;
        rem = v;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(2^-j) in q.30
    function automatic logic [30:0] exp2_tap(input int j);
        logic [63:0] t;
        t = isqrt64(64'd1 << 61);
        for (int i = 1; i < j; i++) begin
            t = isqrt64(t << 30);
        end
        return t[30:0];
    endfunction

endpackage

/* design/pgs_pow.sv */
module pgs_pow import pgs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    input  logic        [30:0] i_m,
    input  logic        [5:0]  i_p,
    input  logic        [15:0] i_exp,
    output t_ctl               o_ctl,
    output logic        [30:0] o_mant,
    output logic signed [15:0] o_k
);

    // log2 fraction, one squaring per stage
    t_ctl        r_lc [1:LOG_STEPS];
    logic [30:0] r_lm [1:LOG_STEPS];
    logic [15:0] r_lf [1:LOG_STEPS];
    logic [5:0]  r_lp [1:LOG_STEPS];

    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
        t_ctl        c_in;
        logic [30:0] m_in;
        logic [15:0] f_in;
        logic [5:0]  p_in;
        logic [61:0] sq;
        logic [31:0] q;
        if (g == 0) begin : g_first
            assign c_in = i_ctl;
            assign m_in = i_m;
            assign f_in = '0;
            assign p_in = i_p;
        end else begin : g_next
            assign c_in = r_lc[g];
            assign m_in = r_lm[g];
            assign f_in = r_lf[g];
            assign p_in = r_lp[g];
        end
        assign sq = 62'(m_in) * 62'(m_in);
        assign q  = sq[61:30];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lc[g+1] <= '0;
            end else begin
                r_lc[g+1] <= c_in;
            end
            r_lm[g+1] <= q[31] ? q[31:1] : q[30:0];
            r_lf[g+1] <= {f_in[14:0], q[31]};
            r_lp[g+1] <= p_in;
        end
    end

    // y = e * log2(d)
    logic signed [6:0]  pm;
    logic signed [22:0] lg;
    logic signed [39:0] n_y;
    t_ctl               r_yc;
    logic signed [39:0] r_y;

    assign pm  = $signed({1'b0, r_lp[LOG_STEPS]}) - 7'sd42;
    assign lg  = $signed({pm, r_lf[LOG_STEPS]});
    assign n_y = 40'($signed({1'b0, i_exp}) * lg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yc <= '0;
        end else begin
            r_yc <= r_lc[LOG_STEPS];
        end
        r_y <= n_y;
    end

    // 2^frac as a product of taps
    t_ctl               r_ec [1:EXP_STEPS];
    logic        [30:0] r_em [1:EXP_STEPS];
    logic        [15:0] r_ef [1:EXP_STEPS];
    logic signed [15:0] r_ek [1:EXP_STEPS];

    for (genvar g = 0; g < EXP_STEPS; g++) begin : g_exp
        localparam logic [30:0] TAP = exp2_tap(g + 1);
        t_ctl               c_in;
        logic        [30:0] m_in;
        logic        [15:0] f_in;
        logic signed [15:0] k_in;
        logic        [61:0] pr;
        if (g == 0) begin : g_first
            assign c_in = r_yc;
            assign m_in = 31'd1 << 30;
            assign f_in = r_y[23:8];
            assign k_in = r_y[39:24];
        end else begin : g_next
            assign c_in = r_ec[g];
            assign m_in = r_em[g];
            assign f_in = r_ef[g];
            assign k_in = r_ek[g];
        end
        assign pr = 62'(m_in) * 62'(TAP);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ec[g+1] <= '0;
            end else begin
                r_ec[g+1] <= c_in;
            end
            r_em[g+1] <= f_in[EXP_STEPS-1-g] ? pr[60:30] : m_in;
            r_ef[g+1] <= f_in;
            r_ek[g+1] <= k_in;
        end
    end

    assign o_ctl  = r_ec[EXP_STEPS];
    assign o_mant = r_em[EXP_STEPS];
    assign o_k    = r_ek[EXP_STEPS];

endmodule

/* design/phong_glossy_specular.sv */
// Phong specular lobe: each beat carries normal, light and view vectors (signed
// q1.14) and yields ks * (r.v)^e in unsigned q2.14, saturated, with o_lobe_zero
// set and intensity 0 when the reflected direction faces away from the view.
// A beat is taken every cycle (o_busy stays low) and its result shows on the
// o_valid strobe; most of the pipeline depth lies in the 16 squaring stages of
// the log2 and the 16 tap-product stages of the exp2.
// The receiver cannot stall. Write registers only when no beat is in flight.
module phong_glossy_specular import pgs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic signed [15:0] i_light_x,
    input  logic signed [15:0] i_light_y,
    input  logic signed [15:0] i_light_z,
    input  logic signed [15:0] i_view_x,
    input  logic signed [15:0] i_view_y,
    input  logic signed [15:0] i_view_z,
    input  logic               i_cfg_we,
    input  logic        [1:0]  i_cfg_idx,
    input  logic        [15:0] i_cfg_data,
    output logic               o_valid,
    output logic        [15:0] o_specular_intensity,
    output logic               o_lobe_zero
);

    logic [15:0] r_gain;
    logic [15:0] r_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= 16'd16384;
            r_exp  <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SPECULAR_GAIN: r_gain <= i_cfg_data;
                REG_LOBE_EXPONENT: r_exp  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic signed [15:0] nv [3];
    logic signed [15:0] lv [3];
    logic signed [15:0] vv [3];
    assign nv[0] = i_normal_x;
    assign nv[1] = i_normal_y;
    assign nv[2] = i_normal_z;
    assign lv[0] = i_light_x;
    assign lv[1] = i_light_y;
    assign lv[2] = i_light_z;
    assign vv[0] = i_view_x;
    assign vv[1] = i_view_y;
    assign vv[2] = i_view_z;

    // stage 1: n_i * wi_i
    logic               r_v1;
    logic signed [31:0] r_p1 [3];
    logic signed [15:0] r_n1 [3];
    logic signed [15:0] r_l1 [3];
    logic signed [15:0] r_w1 [3];
    // stage 2: n.wi
    logic               r_v2;
    logic signed [32:0] r_ndw;
    logic signed [15:0] r_n2 [3];
    logic signed [15:0] r_l2 [3];
    logic signed [15:0] r_w2 [3];
    // stage 3: n_i * (n.wi)
    logic               r_v3;
    logic signed [48:0] r_t3 [3];
    logic signed [15:0] r_l3 [3];
    logic signed [15:0] r_w3 [3];
    // stage 4: reflected vector
    logic               r_v4;
    logic signed [36:0] r_r4 [3];
    logic signed [15:0] r_w4 [3];
    // stage 5: r_i * wo_i
    logic               r_v5;
    logic signed [52:0] r_q5 [3];

    logic signed [36:0] n_r [3];
    logic signed [49:0] rnd [3];

    for (genvar i = 0; i < 3; i++) begin : g_vec
        assign rnd[i] = ($signed({r_t3[i][48], r_t3[i]}) + 50'sd4096) >>> 13;
        assign n_r[i] = rnd[i][36:0] - 37'($signed(r_l3[i]) * 37'sd16384);
        always_ff @(posedge i_clk) begin
            r_p1[i] <= nv[i] * lv[i];
            r_n1[i] <= nv[i];
            r_l1[i] <= lv[i];
            r_w1[i] <= vv[i];
            r_n2[i] <= r_n1[i];
            r_l2[i] <= r_l1[i];
            r_w2[i] <= r_w1[i];
            r_t3[i] <= 49'(r_n2[i] * r_ndw);
            r_l3[i] <= r_l2[i];
            r_w3[i] <= r_w2[i];
            r_r4[i] <= n_r[i];
            r_w4[i] <= r_w3[i];
            r_q5[i] <= 53'(r_r4[i] * r_w4[i]);
        end
    end

    logic signed [54:0] n_d;
    assign n_d = 55'(r_q5[0]) + 55'(r_q5[1]) + 55'(r_q5[2]);

    // stage 6: d and its sign
    t_ctl        r_c6;
    logic [50:0] r_d6;
    // stage 7: leading one
    t_ctl        r_c7;
    logic [50:0] r_d7;
    logic [5:0]  r_p7;
    // stage 8: mantissa
    t_ctl        r_c8;
    logic [30:0] r_m8;
    logic [5:0]  r_p8;

    logic [5:0]  n_p;
    logic [50:0] nrm;

    always_comb begin
        n_p = '0;
        for (int i = 0; i < 51; i++) begin
            if (r_d6[i]) n_p = 6'(i);
        end
    end

    assign nrm = r_d7 << (6'd50 - r_p7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_c6 <= '0;
            r_c7 <= '0;
            r_c8 <= '0;
        end else begin
            r_v1      <= i_start;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_v4      <= r_v3;
            r_v5      <= r_v4;
            r_c6.vld  <= r_v5;
            r_c6.zero <= (n_d <= 55'sd0);
            r_c7      <= r_c6;
            r_c8      <= r_c7;
        end
        r_ndw <= 33'(r_p1[0]) + 33'(r_p1[1]) + 33'(r_p1[2]);
        r_d6  <= n_d[50:0];
        r_d7  <= r_d6;
        r_p7  <= n_p;
        r_m8  <= nrm[50:20];
        r_p8  <= r_p7;
    end

    t_ctl               pw_c;
    logic        [30:0] pw_m;
    logic signed [15:0] pw_k;

    pgs_pow u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_c8),
        .i_m     (r_m8),
        .i_p     (r_p8),
        .i_exp   (r_exp),
        .o_ctl   (pw_c),
        .o_mant  (pw_m),
        .o_k     (pw_k)
    );

    // gain product
    t_ctl               r_c42;
    logic        [46:0] r_prod;
    logic signed [15:0] r_k42;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c42 <= '0;
        end else begin
            r_c42 <= pw_c;
        end
        r_prod <= 47'(r_gain) * 47'(pw_m);
        r_k42  <= pw_k;
    end

    // scale by 2^k with round half up, then saturate
    logic signed [16:0] sft;
    logic        [46:0] tr;
    logic        [46:0] rq;
    logic        [15:0] n_res;

    assign sft = 17'sd29 - 17'(r_k42);
    assign tr  = r_prod >> sft[5:0];
    assign rq  = (tr + 47'd1) >> 1;

    always_comb begin
        if (r_c42.zero || r_prod == '0) begin
            n_res = '0;
        end else if (r_k42 >= 16'sd30) begin
            n_res = 16'hFFFF;
        end else if (sft >= 17'sd62) begin
            n_res = '0;
        end else if (rq > 47'd65535) begin
            n_res = 16'hFFFF;
        end else begin
            n_res = rq[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_c42.vld;
        end
        o_specular_intensity <= n_res;
        o_lobe_zero          <= r_c42.zero;
    end

endmodule

/* design/pgs_checker.sv */
module pgs_checker import pgs_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_valid,
    input logic [15:0] o_specular_intensity,
    input logic        o_lobe_zero
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, PIPE_LAT))
        else $error("result beat without matching start");

    a_zero_lobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_lobe_zero) |-> (o_specular_intensity == 16'd0))
        else $error("zero lobe with nonzero intensity");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

endmodule

bind phong_glossy_specular pgs_checker u_pgs_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_start              (i_start),
    .o_busy               (o_busy),
    .o_valid              (o_valid),
    .o_specular_intensity (o_specular_intensity),
    .o_lobe_zero          (o_lobe_zero)
);

/* tb/phong_glossy_specular_test.sv */
`timescale 1ns / 1ps

module phong_glossy_specular_test;
    import pgs_pkg::*;

    localparam logic [1:0] REG_SPARE_2 = 2'd2;
    localparam logic [1:0] REG_SPARE_3 = 2'd3;
    localparam int SETTLE_CYCLES = PIPE_LAT + 8;
    localparam int STALL_LIMIT   = 1000;

    // nine components: normal xyz, light xyz, view xyz
    typedef logic [8:0][15:0] t_beat;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic signed [15:0] i_normal_x, i_normal_y, i_normal_z;
    logic signed [15:0] i_light_x, i_light_y, i_light_z;
    logic signed [15:0] i_view_x, i_view_y, i_view_z;
    logic               i_cfg_we;
    logic        [1:0]  i_cfg_idx;
    logic        [15:0] i_cfg_data;
    logic               o_valid;
    logic        [15:0] o_specular_intensity;
    logic               o_lobe_zero;

    phong_glossy_specular i_dut (.*);

    logic [15:0] gain_reg;
    logic [15:0] expo_reg;
    logic [63:0] exp2_taps [1:16];
    logic [16:0] expected_lobes [$];
    int          mismatches;
    int          idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] rem;
        res = '0;
        rem = v;
        for (int b = 31; b >= 0; b--) begin
            if ((res | (64'd1 << b)) * (res | (64'd1 << b)) <= rem) begin
                res = res | (64'd1 << b);
            end
        end
        return res;
    endfunction

    // returns {lobe_zero, intensity}
    function automatic logic [16:0] shade_lobe(input t_beat b);
        longint n [3];
        longint wi [3];
        longint wo [3];
        longint r [3];
        longint ndw;
        longint d;
        longint log_d;
        longint y;
        longint k;
        longint s;
        logic [63:0] m;
        logic [63:0] pw;
        logic [63:0] prod;
        logic [63:0] res;
        logic [15:0] f;
        int p;
        for (int i = 0; i < 3; i++) begin
            n[i]  = longint'($signed(b[i]));
            wi[i] = longint'($signed(b[3 + i]));
            wo[i] = longint'($signed(b[6 + i]));
        end
        ndw = n[0] * wi[0] + n[1] * wi[1] + n[2] * wi[2];
        for (int i = 0; i < 3; i++) begin
            r[i] = -wi[i] * 16384 + ((2 * n[i] * ndw + 8192) >>> 14);
        end
        d = r[0] * wo[0] + r[1] * wo[1] + r[2] * wo[2];
        if (d <= 0) begin
            return {1'b1, 16'd0};
        end
        p = 62;
        while (p > 0 && d[p] == 1'b0) p--;
        m = (p >= 30) ? (64'(d) >> (p - 30)) : (64'(d) << (30 - p));
        log_d = 0;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            log_d = log_d << 1;
            if (m >= (64'd1 << 31)) begin
                log_d = log_d | 1;
                m = m >> 1;
            end
        end
        log_d = longint'(p - 42) * 65536 + log_d;
        y = longint'(expo_reg) * log_d;
        k = y >>> 24;
        f = y[23:8];
        pw = 64'd1 << 30;
        for (int j = 1; j <= 16; j++) begin
            if (f[16 - j]) pw = (pw * exp2_taps[j]) >> 30;
        end
        prod = 64'(gain_reg) * pw;
        s = 30 - k;
        if (prod == 0) res = 0;
        else if (s <= 0) res = 65535;
        else if (s >= 63) res = 0;
        else res = (prod + (64'd1 << (s - 1))) >> s;
        if (res > 65535) res = 65535;
        return {1'b0, res[15:0]};
    endfunction

    task automatic send_beat(input t_beat b);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        {i_view_z, i_view_y, i_view_x, i_light_z, i_light_y, i_light_x,
         i_normal_z, i_normal_y, i_normal_x} <= b;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        expected_lobes.push_back(shade_lobe(b));
    endtask

    task automatic drain_pipe();
        i_start <= 1'b0;
        while (expected_lobes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_SPECULAR_GAIN) gain_reg = val;
        else if (idx == REG_LOBE_EXPONENT) expo_reg = val;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 32768) - 16384);
            2: return 16'($urandom_range(0, 512) - 256);
            3: return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
            default: return ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    // mirror-like beat: view close to the reflected light, so the lobe is lit
    function automatic t_beat aligned_beat();
        t_beat b;
        int ax;
        ax = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
            b[i]     = (i == ax) ? 16'sd16384 : 16'(int'($urandom_range(0, 1024)) - 512);
            b[3 + i] = 16'(int'($urandom_range(0, 16384)) - 8192);
        end
        b[3 + ax] = 16'($urandom_range(4096, 16384));
        for (int i = 0; i < 3; i++) begin
            b[6 + i] = (i == ax) ? b[3 + i]
                                 : 16'(-int'($signed(b[3 + i])) + int'($urandom_range(0, 2048)) - 1024);
        end
        return b;
    endfunction

    function automatic t_beat noise_beat();
        t_beat b;
        for (int i = 0; i < 9; i++) b[i] = rand_comp();
        return b;
    endfunction

    task automatic test_extremes();
        t_beat b;
        for (int i = 0; i < 9; i++) b[i] = 16'sd16384;
        send_beat(b);
        for (int i = 0; i < 9; i++) b[i] = -16'sd16384;
        send_beat(b);
        send_beat('0);
        send_beat({9{16'h7fff}});
        send_beat({9{16'h8000}});
        send_beat({9{16'hffff}});
        send_beat({9{16'h0001}});
    endtask

    task automatic test_mirror_and_back();
        t_beat b;
        // n = x, light = x: reflection equals light, view on it gives d^e = 1
        b = '0;
        b[0] = 16'sd16384;
        b[3] = 16'sd16384;
        b[6] = 16'sd16384;
        send_beat(b);
        // view exactly opposite the reflection: lobe not positive
        b[6] = -16'sd16384;
        send_beat(b);
        // grazing view, tiny power
        b[6] = 16'sd1;
        b[7] = 16'sd16384;
        send_beat(b);
        // unnormalized large vectors, saturation
        b = {9{16'h7fff}};
        b[3] = 16'h7fff;
        send_beat(b);
        for (int i = 0; i < 6; i++) send_beat(aligned_beat());
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 7) send_beat(aligned_beat());
            else send_beat(noise_beat());
            if (i == count / 2) begin
                drain_pipe();
            end
        end
    endtask

    task automatic test_reg_sweep();
        // extremes of both registers, then random settings
        logic [15:0] gains [4];
        logic [15:0] expos [4];
        gains = '{16'd0, 16'd65535, 16'd16384, 16'd1};
        expos = '{16'd0, 16'd65535, 16'd1, 16'd2560};
        for (int i = 0; i < 4; i++) begin
            drain_pipe();
            write_reg(REG_SPECULAR_GAIN, gains[i]);
            write_reg(REG_LOBE_EXPONENT, expos[i]);
            write_reg(REG_SPARE_2, 16'($urandom));
            test_random(40);
        end
        for (int i = 0; i < 6; i++) begin
            drain_pipe();
            write_reg(REG_SPECULAR_GAIN, 16'($urandom));
            write_reg(REG_LOBE_EXPONENT, 16'($urandom_range(0, 8192)));
            write_reg(REG_SPARE_3, 16'($urandom));
            test_random(70);
        end
    endtask

    always @(posedge i_clk) begin
        logic [16:0] want;
        if (i_rst_n && o_valid) begin
            if (expected_lobes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: %0d zero=%0b",
                                               o_specular_intensity, o_lobe_zero);
            end else begin
                want = expected_lobes.pop_front();
                if (want != {o_lobe_zero, o_specular_intensity}) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: want %0d zero=%0b, got %0d zero=%0b",
                                 want[15:0], want[16], o_specular_intensity, o_lobe_zero);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        mismatches  = 0;
        idle_cycles = 0;
        gain_reg    = 16'd16384;
        expo_reg    = 16'd256;
        for (int j = 1; j <= 16; j++) begin
            exp2_taps[j] = (j == 1) ? int_sqrt(64'd1 << 61) : int_sqrt(exp2_taps[j - 1] << 30);
        end
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_SPECULAR_GAIN;
        i_cfg_data = '0;
        {i_view_z, i_view_y, i_view_x, i_light_z, i_light_y, i_light_x,
         i_normal_z, i_normal_y, i_normal_x} = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_mirror_and_back();
        test_random(80);
        test_reg_sweep();
        drain_pipe();

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
